// ----- hw/rtl/zcfe_pkg.sv -----
// Package with the shared widths and constants of the zero-crossing frequency estimator.
`timescale 1ns / 1ps
package zcfe_pkg;
    localparam int FRAC_BITS = 24;
    localparam int TIME_BITS = 32;
    localparam int CNT_BITS  = 17;
    localparam int FREQ_BITS = 32;
    localparam int LVL_BITS  = 16;
    // Crossing times are Q32.24 with a sign bit and one more bit of headroom.
    localparam int CT_BITS   = TIME_BITS + FRAC_BITS + 2;
endpackage

// ----- hw/rtl/zcfe_if.sv -----
// Valid/ready channel interfaces for the samples and the results.
`timescale 1ns / 1ps
interface zcfe_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [31:0]                   sample_time;
    logic                          window_first;
    logic                          window_last;
    modport source (output valid, sample, sample_time, window_first, window_last,
                    input ready);
    modport sink (input valid, sample, sample_time, window_first, window_last,
                  output ready);
endinterface

interface zcfe_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] frequency;
    logic [16:0] crossing_count;
    logic        status;
    modport source (output valid, frequency, crossing_count, status, input ready);
    modport sink (input valid, frequency, crossing_count, status, output ready);
endinterface

// ----- hw/rtl/zcfe_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module zcfe_div
    import zcfe_pkg::*;
#(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 64,
    parameter int Q_BITS   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_rem,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [Q_BITS-1:0]   o_quo
);
    localparam int CW = $clog2(Q_BITS + 1);
    localparam int RW = (NUM_BITS > DEN_BITS ? NUM_BITS : DEN_BITS) + 1;

    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     n_sh;
    logic [DEN_BITS-1:0] r_den;
    logic [Q_BITS-1:0] r_quo;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              w_ge;

    assign n_sh = {r_rem[RW-2:0], 1'b0};
    assign w_ge = n_sh >= RW'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_rem  <= RW'(i_rem);
                r_den  <= i_den;
                r_quo  <= '0;
                r_cnt  <= CW'(Q_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? n_sh - RW'(r_den) : n_sh;
                r_quo <= {r_quo[Q_BITS-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_quo;
endmodule

// ----- hw/rtl/zero_crossing_frequency_estimator_top.sv -----
// Top level of the zero-crossing frequency estimator.
`timescale 1ns / 1ps
// A sample that is not the last of its window leaves the input ready for the
// next sample. After the last sample of a window is accepted, the input stays busy
// while the result is formed. With fewer than two crossings S_T1 goes straight
// to S_OUT. Otherwise one shared divider, one quotient bit per cycle, runs for
// each crossing fraction and then for the frequency, each run started from a
// setup state. A zero span or a saturated frequency skips the last run. The
// result beat then waits in an output register until it is taken, and a new
// result waits while that register is full.
module zero_crossing_frequency_estimator_top
    import zcfe_pkg::*;
#(
    parameter int MAX_WINDOW  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LVL_BITS-1:0] i_cfg_data,
    zcfe_in_if.sink             i_in,
    zcfe_out_if.source          o_out
);
    localparam int SB   = SAMPLE_BITS;
    localparam int DB   = SB + 1;
    localparam int CNTW = $clog2(MAX_WINDOW + 1);
    localparam int RB   = CNTW + FRAC_BITS;
    localparam int NW   = (RB > DB) ? RB : DB;
    localparam int HB   = LVL_BITS + SB;

    typedef enum logic [3:0] {
        S_IDLE, S_F1, S_F1W, S_T1, S_F2, S_F2W, S_T2, S_SPAN, S_DIV, S_DIVW, S_OUT
    } t_state;

    t_state r_state;
    logic [LVL_BITS-1:0] r_lvl;
    logic signed [SB-1:0] r_prev_s, r_fs0, r_fs1, r_ls0, r_ls1;
    logic [TIME_BITS-1:0] r_prev_t, r_ft0, r_ft1, r_lt0, r_lt1;
    logic r_pol, r_hold;
    logic [CNTW-1:0] r_cnt;
    logic signed [CT_BITS-1:0] r_ti, r_tf;
    logic [CT_BITS-1:0] r_span;
    logic [FREQ_BITS-1:0] r_freq;
    logic r_status, r_ovalid;

    logic signed [SB-1:0] w_s;
    logic w_acc, w_nonneg;
    logic [SB-1:0] w_mag;
    logic w_cross, w_cnt1;
    logic [CNTW-1:0] w_cnt;

    assign w_s = i_in.sample;
    assign w_acc = i_in.valid && i_in.ready;
    assign w_nonneg = !w_s[SB-1];
    assign w_mag = w_s[SB-1] ? SB'(-w_s) : w_s;
    assign w_cross = !i_in.window_first && !r_hold && (w_nonneg != r_pol);
    assign w_cnt = (r_cnt < CNTW'(MAX_WINDOW)) ? r_cnt + 1'b1 : r_cnt;
    assign w_cnt1 = w_cnt == CNTW'(1);

    // Divider operand selection.
    logic signed [SB-1:0] w_a0, w_a1;
    logic [DB-1:0] w_am, w_dm;
    logic signed [DB:0] w_d;
    logic w_clamp;
    logic [NW-1:0] w_num;
    logic [CT_BITS+9:0] w_den;
    logic w_start, w_done;
    logic [FREQ_BITS-1:0] w_quo;
    logic [RB-1:0] w_r;

    assign w_a0 = (r_state == S_F1 || r_state == S_F1W) ? r_fs0 : r_ls0;
    assign w_a1 = (r_state == S_F1 || r_state == S_F1W) ? r_fs1 : r_ls1;
    assign w_am = w_a1[SB-1] ? DB'(-$signed({w_a1[SB-1], w_a1})) : DB'(w_a1);
    assign w_d = $signed({{2{w_a0[SB-1]}}, w_a0}) - $signed({{2{w_a1[SB-1]}}, w_a1});
    assign w_dm = w_d[DB] ? DB'(-w_d) : DB'(w_d);
    assign w_clamp = w_am >= w_dm;
    assign w_r = RB'(r_cnt - 1'b1) << (FRAC_BITS - 1);
    assign w_start = r_state == S_F1 || r_state == S_F2 || r_state == S_DIV;

    // Fractions divide |s1| by |s0 - s1|; the frequency divides (count - 1) * 2^23 by the span.
    always_comb begin
        if (r_state == S_DIV) begin
            w_num = NW'(w_r);
            w_den = (CT_BITS + 10)'(r_span);
        end else begin
            w_num = NW'(w_am);
            w_den = (CT_BITS + 10)'(w_dm);
        end
    end

    // The fraction divide produces a 32-bit quotient floor(num*2^32/den) when
    // num < den; its top 24 bits match truncation, since
    // floor(num*2^32/den) >> 8 equals floor(num*2^24/den), so the fraction
    // takes quotient >> 8.
    zcfe_div #(.NUM_BITS(NW), .DEN_BITS(CT_BITS + 10), .Q_BITS(FREQ_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_rem  (w_num),
        .i_den  (w_den),
        .o_done (w_done),
        .o_quo  (w_quo)
    );

    logic [FRAC_BITS:0] w_frac;
    logic [TIME_BITS-1:0] w_dt, w_rel;
    logic signed [CT_BITS-1:0] w_ct;
    assign w_frac = w_clamp ? (FRAC_BITS + 1)'(1) << FRAC_BITS
                            : (FRAC_BITS + 1)'(w_quo >> (FREQ_BITS - FRAC_BITS));
    assign w_dt = (r_state == S_F1W) ? r_ft1 - r_ft0 : r_lt1 - r_lt0;
    assign w_rel = (r_state == S_F1W) ? '0 : r_lt1 - r_ft1;
    assign w_ct = $signed(CT_BITS'({w_rel, FRAC_BITS'(0)}))
                - $signed(CT_BITS'(w_frac * w_dt));

    logic signed [CT_BITS-1:0] w_span;
    assign w_span = r_tf - r_ti;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lvl    <= '0;
            r_prev_s <= '0;
            r_prev_t <= '0;
            r_pol    <= 1'b0;
            r_hold   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lvl <= i_cfg_data;
            end
            if (o_out.valid && o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_in.window_first) begin
                            r_pol  <= w_nonneg;
                            r_cnt  <= '0;
                            r_hold <= 1'b0;
                        end else if (r_hold) begin
                            r_hold <= HB'(w_mag) > HB'(r_lvl);
                        end else if (w_cross) begin
                            r_cnt <= w_cnt;
                            r_ls0 <= r_prev_s;
                            r_ls1 <= w_s;
                            r_lt0 <= r_prev_t;
                            r_lt1 <= i_in.sample_time;
                            if (w_cnt1) begin
                                r_fs0 <= r_prev_s;
                                r_fs1 <= w_s;
                                r_ft0 <= r_prev_t;
                                r_ft1 <= i_in.sample_time;
                            end
                            r_pol  <= w_nonneg;
                            r_hold <= 1'b1;
                        end
                        r_prev_s <= w_s;
                        r_prev_t <= i_in.sample_time;
                        if (i_in.window_last) begin
                            r_state <= S_T1;
                        end
                    end
                end
                S_T1: begin
                    r_freq   <= '0;
                    r_status <= 1'b1;
                    r_state  <= (r_cnt >= CNTW'(2)) ? S_F1 : S_OUT;
                end
                S_F1: r_state <= S_F1W;
                S_F1W: begin
                    if (w_done) begin
                        r_ti    <= w_ct;
                        r_state <= S_F2;
                    end
                end
                S_F2: r_state <= S_F2W;
                S_F2W: begin
                    if (w_done) begin
                        r_tf    <= w_ct;
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    r_span <= CT_BITS'(w_span);
                    if (w_span > 0) begin
                        r_status <= 1'b0;
                        if (CT_BITS'(w_r) >= CT_BITS'(w_span)) begin
                            r_freq  <= '1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: r_state <= S_DIVW;
                S_DIVW: begin
                    if (w_done) begin
                        r_freq  <= w_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [FREQ_BITS-1:0] r_ofreq;
    logic [CNTW-1:0]      r_ocnt;
    logic                 r_ostat;
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || o_out.ready)) begin
            r_ofreq <= r_freq;
            r_ocnt  <= r_cnt;
            r_ostat <= r_status;
        end
    end

    assign i_in.ready           = r_state == S_IDLE;
    assign o_out.valid          = r_ovalid;
    assign o_out.frequency      = r_ofreq;
    assign o_out.crossing_count = CNT_BITS'(r_ocnt);
    assign o_out.status         = r_ostat;
endmodule

// ----- bench/zero_crossing_frequency_estimator_top_tb.sv -----
// Self-checking testbench of the zero-crossing frequency estimator top level.
`timescale 1ns / 1ps
module zero_crossing_frequency_estimator_top_tb;
    import zcfe_pkg::*;

    typedef struct {
        logic [FREQ_BITS-1:0] frequency;
        logic [CNT_BITS-1:0]  crossing_count;
        logic                 status;
    } t_estimate;

    localparam int MAX_CROSSINGS = 65536;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LVL_BITS-1:0] i_cfg_data;

    zcfe_in_if #(.SAMPLE_BITS(16)) in_ch ();
    zcfe_out_if out_ch ();

    zero_crossing_frequency_estimator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor state.
    logic [LVL_BITS-1:0]  level;
    logic signed [15:0]   prev_s;
    logic [31:0]          prev_t;
    logic                 pol;
    logic                 hold;
    int                   cnt;
    logic signed [15:0]   fp_s0, fp_s1, lp_s0, lp_s1;
    logic [31:0]          fp_t0, fp_t1, lp_t0, lp_t1;

    t_estimate expected_estimates[$];
    int  errors;
    int  beats_in;
    int  estimates_seen;
    int  quiet_cycles;
    bit  idle_en;
    bit  long_hold;
    bit  any_first;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint crossing_q24(logic signed [15:0] s0, logic signed [15:0] s1,
                                            logic [31:0] t0, logic [31:0] t1,
                                            logic [31:0] base);
        longint a, d, frac;
        logic [31:0] dt, rel;
        a = (s1 < 0) ? -longint'(s1) : longint'(s1);
        d = longint'(s0) - longint'(s1);
        if (d < 0) d = -d;
        dt = t1 - t0;
        rel = t1 - base;
        if (a >= d) frac = longint'(1) << FRAC_BITS;
        else frac = (a << FRAC_BITS) / d;
        return (longint'({32'b0, rel}) << FRAC_BITS) - frac * longint'({32'b0, dt});
    endfunction

    function automatic logic [31:0] frequency_q32(int count, logic [63:0] span);
        logic [63:0] r;
        logic [31:0] f;
        r = 64'(count - 1) << (FRAC_BITS - 1);
        f = '0;
        if (r >= span) return 32'hFFFF_FFFF;
        for (int k = 0; k < 32; k++) begin
            r = r << 1;
            f = f << 1;
            if (r >= span) begin
                r = r - span;
                f[0] = 1'b1;
            end
        end
        return f;
    endfunction

    task automatic predict_sample(logic signed [15:0] s, logic [31:0] t, bit first, bit last);
        bit nonneg;
        int mag;
        longint ti, tf, span;
        t_estimate e;
        nonneg = (s >= 0);
        mag = (s < 0) ? -int'(s) : int'(s);
        if (first) begin
            pol = nonneg;
            cnt = 0;
            hold = 1'b0;
        end else if (hold) begin
            hold = (mag > int'(level));
        end else if (nonneg != pol) begin
            if (cnt < MAX_CROSSINGS) cnt++;
            lp_s0 = prev_s; lp_s1 = s; lp_t0 = prev_t; lp_t1 = t;
            if (cnt == 1) begin
                fp_s0 = prev_s; fp_s1 = s; fp_t0 = prev_t; fp_t1 = t;
            end
            pol = nonneg;
            hold = 1'b1;
        end
        prev_s = s;
        prev_t = t;
        if (last) begin
            e.frequency = '0;
            e.status = 1'b1;
            e.crossing_count = cnt[CNT_BITS-1:0];
            if (cnt >= 2) begin
                ti = crossing_q24(fp_s0, fp_s1, fp_t0, fp_t1, fp_t1);
                tf = crossing_q24(lp_s0, lp_s1, lp_t0, lp_t1, fp_t1);
                span = tf - ti;
                if (span > 0) begin
                    e.status = 1'b0;
                    e.frequency = frequency_q32(cnt, span);
                end
            end
            expected_estimates.push_back(e);
        end
    endtask

    task automatic send_beat(logic signed [15:0] s, logic [31:0] t, bit first, bit last);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample       <= s;
        in_ch.sample_time  <= t;
        in_ch.window_first <= first;
        in_ch.window_last  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        beats_in++;
        if (first) any_first = 1'b1;
        predict_sample(s, t, first, last);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_estimates.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_level(logic [LVL_BITS-1:0] v);
        wait_drained();
        repeat (130) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        level = v;
    endtask

    // A window shaped like a noisy oscillation: runs of one sign with random length.
    task automatic send_wave(int n, int amp, int max_dt);
        logic [31:0] t;
        bit neg;
        int run;
        int v;
        t = $urandom;
        neg = $urandom_range(0, 1);
        run = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if (run == 0) begin
                neg = !neg;
                run = $urandom_range(1, 6);
            end
            run--;
            v = $urandom_range(0, amp);
            if ($urandom_range(0, 15) == 0) v = 0;
            send_beat(neg ? 16'(-v) : 16'(v), t, i == 0, i == n - 1);
            t = t + ($urandom_range(0, 20) == 0 ? $urandom : $urandom_range(0, max_dt));
        end
    endtask

    task automatic test_before_first_window();
        send_beat(16'sd100, 32'd10, 1'b0, 1'b0);
        send_beat(-16'sd200, 32'd20, 1'b0, 1'b0);
        send_beat(16'sd0, 32'd30, 1'b0, 1'b0);
        send_beat(-16'sd300, 32'd40, 1'b0, 1'b0);
        send_beat(16'sd0, 32'd50, 1'b0, 1'b0);
        send_beat(16'sd400, 32'd60, 1'b0, 1'b1);
    endtask

    task automatic test_extremes();
        send_beat(16'sh7FFF, 32'hFFFF_FFF0, 1'b1, 1'b0);
        send_beat(-16'sh8000, 32'hFFFF_FFF8, 1'b0, 1'b0);
        send_beat(16'sd0, 32'h0000_0004, 1'b0, 1'b0);
        send_beat(-16'sh8000, 32'h0000_0010, 1'b0, 1'b0);
        send_beat(16'sh7FFF, 32'h0000_0020, 1'b0, 1'b1);
    endtask

    task automatic test_special_windows();
        send_beat(-16'sd5, 32'd7, 1'b1, 1'b1);
        // Clamped fraction: a zero sample clears the hold-off, the next one crosses.
        send_beat(16'sd100, 32'd100, 1'b1, 1'b0);
        send_beat(-16'sd100, 32'd110, 1'b0, 1'b0);
        send_beat(16'sd0, 32'd120, 1'b0, 1'b0);
        send_beat(16'sd10, 32'd130, 1'b0, 1'b0);
        send_beat(-16'sd10, 32'd140, 1'b0, 1'b0);
        send_beat(16'sd20, 32'd150, 1'b0, 1'b1);
        // Zero span: every timestamp equal.
        send_beat(16'sd50, 32'd900, 1'b1, 1'b0);
        send_beat(-16'sd50, 32'd900, 1'b0, 1'b0);
        send_beat(16'sd50, 32'd900, 1'b0, 1'b1);
        // Alternating unit samples at one timestamp, then one a tick later; the hold-off level decides how many cross.
        send_beat(16'sd1, 32'd5000, 1'b1, 1'b0);
        for (int i = 1; i < 10; i++)
            send_beat((i % 2) ? -16'sd1 : 16'sd1, 32'd5000, 1'b0, 1'b0);
        send_beat(16'sd1, 32'd5001, 1'b0, 1'b1);
    endtask

    task automatic test_random_windows(int beats);
        int sent;
        int n;
        sent = 0;
        while (sent < beats) begin
            if ($urandom_range(0, 9) < 8) begin
                n = $urandom_range(2, 30);
                send_wave(n, $urandom_range(0, 9) == 0 ? 32767 : $urandom_range(1, 2000),
                          $urandom_range(1, 1000));
            end else begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send_beat(16'($urandom), $urandom, $urandom_range(0, 3) == 0,
                              $urandom_range(0, 3) == 0);
            end
            sent += n;
        end
    endtask

    task automatic test_output_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 12; i++) send_beat(16'($urandom), $urandom, 1'b1, 1'b1);
        send_wave(10, 500, 40);
    endtask

    task automatic test_drain_pause();
        send_wave(12, 3000, 50);
        wait_drained();
        send_wave(12, 3000, 50);
    endtask

    // Result side: random stalls, one long hold-off on request, checking at the edge.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_estimate e;
        if (i_rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            estimates_seen++;
            if (expected_estimates.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat freq=%h count=%0d status=%0d", $time,
                         out_ch.frequency, out_ch.crossing_count, out_ch.status);
            end else begin
                e = expected_estimates.pop_front();
                if (out_ch.frequency !== e.frequency) begin
                    errors++;
                    $display("%0t: frequency expected %h actual %h", $time, e.frequency,
                             out_ch.frequency);
                end
                if (out_ch.crossing_count !== e.crossing_count) begin
                    errors++;
                    $display("%0t: crossing_count expected %0d actual %0d", $time,
                             e.crossing_count, out_ch.crossing_count);
                end
                if (out_ch.status !== e.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             out_ch.status);
                end
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int limit;
        errors = 0; beats_in = 0; estimates_seen = 0; quiet_cycles = 0;
        idle_en = 1'b1; long_hold = 1'b0; any_first = 1'b0;
        level = '0; prev_s = '0; prev_t = '0; pol = 1'b0; hold = 1'b0; cnt = 0;
        {fp_s0, fp_s1, lp_s0, lp_s1} = '0;
        {fp_t0, fp_t1, lp_t0, lp_t1} = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.sample_time = '0;
        in_ch.window_first = 1'b0;
        in_ch.window_last = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_before_first_window();
        test_extremes();
        write_level(16'd0);
        test_special_windows();
        write_level(16'd32768);
        test_special_windows();
        write_level(16'd40);
        test_random_windows(150);
        test_output_backpressure();
        test_drain_pause();
        write_level(16'($urandom_range(0, 32768)));
        test_random_windows(150);
        write_level(16'd1);
        idle_en = 1'b0;
        test_random_windows(150);

        wait_drained();
        repeat (150) @(negedge i_clk);
        $display("Covered %0d sample beats and %0d estimates over five hysteresis levels,",
                 beats_in, estimates_seen);
        $display("including one-sample, clamped, zero-span and wrapped-time windows.");
        if (errors == 0 && expected_estimates.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d estimates missing", errors,
                     expected_estimates.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/zcfe_pkg.sv
hw/rtl/zcfe_if.sv
hw/rtl/zcfe_div.sv
hw/rtl/zero_crossing_frequency_estimator_top.sv
bench/zero_crossing_frequency_estimator_top_tb.sv
